### sv/ulst_pkg.sv
// Package for the unique sequential list core.
// Holds the transaction structs, operation and status codes and the sequencer states.
// No dependencies.
package ulst_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CAP_W       = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_PRESENT   = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] position;
    logic [4:0] count;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

### sv/unique_sequential_list_core.sv
// Top level of the unique sequential list core.
// Holds the capacity register; instantiates ulst_ctrl and ulst_ram. Depends on ulst_pkg.
//
// Keeps a packed list of distinct 32-bit values. A transaction is taken when start is
// high and busy is low: insert, remove or find of in_data.value. Each transaction gives
// exactly one result on out_data, marked by out_strobe for one cycle; the receiver
// cannot stall, so the result must be taken in that cycle.
// A full insert, a remove on an empty list or an unused operation goes straight to
// the result. Find and insert read the slots one by one, one RAM read per slot, with
// a pipelined compare; remove scans to the matching slot, then compacts the slots
// behind it before the result.
// The shared RAM port, one read and one write per cycle, paces these steps; busy
// stays high until the strobe cycle ends, so one transaction is at work at a time.
// cfg_wdata sets the number of slots in use (capacity); write it only while idle.
// Reset empties the list and sets capacity to 16; no clearing pass is run.
module unique_sequential_list_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ulst_pkg::in_t              in_data,
  output logic                       out_strobe,
  output ulst_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [ulst_pkg::CAP_W-1:0] cfg_wdata
);
  import ulst_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] capacity_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  assign capacity_nxt = cfg_we ? cfg_wdata : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(16);
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  ulst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .capacity  (capacity_r),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ulst_ram #(
    .WIDTH(32),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

### sv/ulst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ulst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/ulst_ctrl.sv
// Sequencer and shared compare unit of the unique sequential list core.
// Scans the entry RAM one slot per cycle, appends, and compacts on remove.
// Depends on ulst_pkg.
module ulst_ctrl (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  ulst_pkg::in_t                            in_data,
  input  logic [ulst_pkg::CAP_W-1:0]               capacity,
  output logic                                     out_strobe,
  output ulst_pkg::out_t                           out_data,
  output logic                                     ram_we,
  output logic [$clog2(ulst_pkg::MAX_ENTRIES)-1:0] ram_waddr,
  output logic [31:0]                              ram_wdata,
  output logic [$clog2(ulst_pkg::MAX_ENTRIES)-1:0] ram_raddr,
  input  logic [31:0]                              ram_rdata
);
  import ulst_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = (CW > CAP_W) ? CW : CAP_W;

  state_t      state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] val_r, val_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] cmp_r, cmp_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          issue;
  logic          hit;
  logic          drained;
  logic          full;
  logic [AW-1:0] shift_addr;

  assign issue      = (idx_r < count_r);
  assign hit        = pend_r && (ram_rdata == val_r);
  assign drained    = !issue && !pend_r;
  assign full       = (KW'(count_r) >= KW'(capacity)) || (count_r == CW'(MAX_ENTRIES));
  assign shift_addr = cmp_r - AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    cmp_r  <= cmp_nxt;
    pos_r  <= pos_nxt;
    stat_r <= stat_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    cmp_nxt   = cmp_r;
    pos_nxt   = pos_r;
    stat_nxt  = stat_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_data.operation;
          val_nxt  = in_data.value;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          pos_nxt  = '0;
          if (in_data.operation == OP_INSERT && full) begin
            stat_nxt  = STAT_FULL;
            state_nxt = S_DONE;
          end else if (in_data.operation == OP_REMOVE && count_r == '0) begin
            stat_nxt  = STAT_EMPTY;
            state_nxt = S_DONE;
          end else if (in_data.operation != OP_INSERT && in_data.operation != OP_REMOVE &&
                       in_data.operation != OP_FIND) begin
            stat_nxt  = STAT_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          pos_nxt = cmp_r;
          case (op_r)
            OP_INSERT: begin
              stat_nxt  = STAT_PRESENT;
              state_nxt = S_DONE;
            end
            OP_REMOVE: begin
              idx_nxt   = CW'(cmp_r) + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
            default: begin
              stat_nxt  = STAT_OK;
              state_nxt = S_DONE;
            end
          endcase
        end else if (drained) begin
          if (op_r == OP_INSERT) begin
            stat_nxt  = STAT_OK;
            pos_nxt   = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
          end else begin
            stat_nxt  = STAT_NOT_FOUND;
          end
          state_nxt = S_DONE;
        end else begin
          pend_nxt = issue;
          cmp_nxt  = idx_r[AW-1:0];
          if (issue) begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_SHIFT: begin
        if (drained) begin
          stat_nxt  = STAT_OK;
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          pend_nxt = issue;
          cmp_nxt  = idx_r[AW-1:0];
          if (issue) begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy              = (state_r != S_IDLE);
    out_strobe        = (state_r == S_DONE);
    out_data.status   = stat_r;
    out_data.position = 4'(pos_r);
    out_data.count    = 5'(count_r);
    ram_raddr         = idx_r[AW-1:0];
    ram_we            = 1'b0;
    ram_waddr         = count_r[AW-1:0];
    ram_wdata         = val_r;
    case (state_r)
      S_SCAN: begin
        ram_we = !hit && drained && (op_r == OP_INSERT);
      end
      S_SHIFT: begin
        ram_we    = pend_r;
        ram_waddr = shift_addr;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

endmodule
